// ===== rtl/htc_pkg.sv =====
// Shared types and constants for the humidity/temperature compensation block.
// Used by htc_mul, htc_seq and humidity_temperature_compensation_top.
package htc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned RES_W  = 18;
	localparam int unsigned IDX_W  = 4;

	localparam logic [IDX_W-1:0] REG_T1   = 4'd0;
	localparam logic [IDX_W-1:0] REG_T2   = 4'd1;
	localparam logic [IDX_W-1:0] REG_T3   = 4'd2;
	localparam logic [IDX_W-1:0] REG_H1   = 4'd3;
	localparam logic [IDX_W-1:0] REG_H2   = 4'd4;
	localparam logic [IDX_W-1:0] REG_H3   = 4'd5;
	localparam logic [IDX_W-1:0] REG_H4H5 = 4'd6;
	localparam logic [IDX_W-1:0] REG_H6   = 4'd7;

	localparam logic signed [31:0] TEMP_MIN        = -32'sd4000;
	localparam logic signed [31:0] TEMP_MAX        = 32'sd8500;
	localparam logic [31:0]        HUM_FINE_OFFSET = 32'd76800;
	localparam logic [31:0]        HUM_ROUND_A     = 32'd16384;
	localparam logic [31:0]        HUM_BIAS_B      = 32'd32768;
	localparam logic [31:0]        HUM_BIAS_C      = 32'd2097152;
	localparam logic [31:0]        HUM_ROUND_D     = 32'd8192;
	localparam logic [31:0]        HUM_LIMIT       = 32'd419430400;
	localparam logic [31:0]        TEMP_ROUND      = 32'd128;

	localparam logic FUNC_TEMP = 1'b0;
	localparam logic FUNC_HUM  = 1'b1;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [7:0]  h1;
		logic signed [15:0] h2;
		logic        [7:0]  h3;
		logic        [23:0] h45;
		logic signed [7:0]  h6;
	} cal_t;

	typedef struct packed {
		logic        start;
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] prod;
	} mul_rsp_t;

endpackage

// ===== rtl/htc_mul.sv =====
// Bit-serial 32x32 multiplier keeping the low 32 bits of the product.
// Depends on htc_pkg for the request and response structs.
module htc_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  htc_pkg::mul_req_t req,
	output htc_pkg::mul_rsp_t rsp
);

	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] acc_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[30:0], 1'b0};
			b_q <= {1'b0, b_q[31:1]};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.prod = acc_q;

endmodule

// ===== rtl/htc_seq.sv =====
// Sequencer for both compensation formulas: steps one shared serial multiplier,
// keeps fine temperature and the result register. Depends on htc_pkg, htc_mul.
module htc_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  htc_pkg::cal_t            cal,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic [19:0]              raw_sample,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     kind,
	output logic signed [17:0]       compensated
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_WAIT, ST_POST, ST_FIN, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		STEP_T1, STEP_T2, STEP_T3,
		STEP_H1, STEP_H2, STEP_H3, STEP_H4, STEP_H5, STEP_H6, STEP_H7, STEP_H8
	} step_t;

	state_t            state_q;
	step_t             step_q;
	logic              func_q;
	logic [19:0]       raw_q;
	logic [31:0]       fine_q;
	logic [31:0]       acc0_q;
	logic [31:0]       acc1_q;
	logic [31:0]       acc2_q;
	logic              out_valid_q;
	logic              kind_q;
	logic signed [17:0] comp_q;

	htc_pkg::mul_req_t mreq;
	htc_pkg::mul_rsp_t mrsp;

	logic [31:0] t_diff_a;
	logic [31:0] t_diff_d;
	logic [31:0] v_hum;
	logic [31:0] h_pre;
	logic [31:0] h4_ext;
	logic [31:0] h5_ext;
	logic [31:0] m;
	logic [31:0] t_scaled;
	logic signed [31:0] t_val;
	logic signed [31:0] t_clamp;
	logic [31:0] h_clamp;

	assign t_diff_a = {15'd0, raw_q[19:3]} - {15'd0, cal.t1, 1'b0};
	assign t_diff_d = {16'd0, raw_q[19:4]} - {16'd0, cal.t1};
	assign v_hum    = fine_q - htc_pkg::HUM_FINE_OFFSET;
	assign h4_ext   = {{20{cal.h45[11]}}, cal.h45[11:0]};
	assign h5_ext   = {{20{cal.h45[23]}}, cal.h45[23:12]};
	assign h_pre    = {2'd0, raw_q[15:0], 14'd0} - {h4_ext[11:0], 20'd0}
		+ htc_pkg::HUM_ROUND_A;
	assign m        = mrsp.prod;
	assign t_scaled = fine_q + {fine_q[29:0], 2'b00} + htc_pkg::TEMP_ROUND;
	assign t_val    = $signed(acc0_q) >>> 8;

	always_comb begin
		if (t_val < htc_pkg::TEMP_MIN) begin
			t_clamp = htc_pkg::TEMP_MIN;
		end else if (t_val > htc_pkg::TEMP_MAX) begin
			t_clamp = htc_pkg::TEMP_MAX;
		end else begin
			t_clamp = t_val;
		end
		if (acc0_q[31]) begin
			h_clamp = '0;
		end else if (acc0_q > htc_pkg::HUM_LIMIT) begin
			h_clamp = htc_pkg::HUM_LIMIT;
		end else begin
			h_clamp = acc0_q;
		end
	end

	always_comb begin
		mreq.start = (state_q == ST_LOAD);
		case (step_q)
			STEP_T1: begin
				mreq.a = t_diff_a;
				mreq.b = 32'($signed(cal.t2));
			end
			STEP_T2: begin
				mreq.a = t_diff_d;
				mreq.b = t_diff_d;
			end
			STEP_T3: begin
				mreq.a = acc1_q;
				mreq.b = 32'($signed(cal.t3));
			end
			STEP_H1: begin
				mreq.a = h5_ext;
				mreq.b = v_hum;
			end
			STEP_H2: begin
				mreq.a = acc2_q;
				mreq.b = 32'($signed(cal.h6));
			end
			STEP_H3: begin
				mreq.a = acc2_q;
				mreq.b = {24'd0, cal.h3};
			end
			STEP_H4: begin
				mreq.a = acc1_q;
				mreq.b = acc2_q;
			end
			STEP_H5: begin
				mreq.a = acc1_q;
				mreq.b = 32'($signed(cal.h2));
			end
			STEP_H6: begin
				mreq.a = acc0_q;
				mreq.b = acc1_q;
			end
			STEP_H7: begin
				mreq.a = acc2_q;
				mreq.b = acc2_q;
			end
			STEP_H8: begin
				mreq.a = acc1_q;
				mreq.b = {24'd0, cal.h1};
			end
			default: begin
				mreq.a = '0;
				mreq.b = '0;
			end
		endcase
	end

	htc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_T1;
			fine_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						raw_q   <= raw_sample;
						step_q  <= (func == htc_pkg::FUNC_HUM) ? STEP_H1 : STEP_T1;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (step_q == STEP_H1) begin
						acc1_q <= h_pre;
						acc2_q <= v_hum;
					end
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mrsp.done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					state_q <= ST_LOAD;
					case (step_q)
						STEP_T1: begin
							acc0_q <= 32'($signed(m) >>> 11);
							step_q <= STEP_T2;
						end
						STEP_T2: begin
							acc1_q <= 32'($signed(m) >>> 12);
							step_q <= STEP_T3;
						end
						STEP_T3: begin
							fine_q  <= acc0_q + 32'($signed(m) >>> 14);
							state_q <= ST_FIN;
						end
						STEP_H1: begin
							acc0_q <= 32'($signed(acc1_q - m) >>> 15);
							step_q <= STEP_H2;
						end
						STEP_H2: begin
							acc1_q <= 32'($signed(m) >>> 10);
							step_q <= STEP_H3;
						end
						STEP_H3: begin
							acc2_q <= 32'($signed(m) >>> 11) + htc_pkg::HUM_BIAS_B;
							step_q <= STEP_H4;
						end
						STEP_H4: begin
							acc1_q <= 32'($signed(m) >>> 10) + htc_pkg::HUM_BIAS_C;
							step_q <= STEP_H5;
						end
						STEP_H5: begin
							acc1_q <= 32'($signed(m + htc_pkg::HUM_ROUND_D) >>> 14);
							step_q <= STEP_H6;
						end
						STEP_H6: begin
							acc0_q <= m;
							acc2_q <= 32'($signed(m) >>> 15);
							step_q <= STEP_H7;
						end
						STEP_H7: begin
							acc1_q <= 32'($signed(m) >>> 7);
							step_q <= STEP_H8;
						end
						STEP_H8: begin
							acc0_q  <= acc0_q - 32'($signed(m) >>> 4);
							state_q <= ST_FIN;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_FIN: begin
					if (func_q == htc_pkg::FUNC_TEMP) begin
						acc0_q <= t_scaled;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						kind_q      <= func_q;
						if (func_q == htc_pkg::FUNC_TEMP) begin
							comp_q <= t_clamp[17:0];
						end else begin
							comp_q <= $signed(h_clamp[29:12]);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign compensated = comp_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mreq.start |-> !mrsp.busy)
		else $error("multiplier started while busy");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == htc_pkg::FUNC_TEMP) |->
		(compensated >= -18'sd4000 && compensated <= 18'sd8500))
		else $error("temperature result out of range");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == htc_pkg::FUNC_HUM) |->
		(compensated >= 18'sd0 && compensated <= 18'sd102400))
		else $error("humidity result out of range");

	a_fine_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> $stable(fine_q))
		else $error("fine temperature changed while idle");

endmodule

// ===== rtl/humidity_temperature_compensation_top.sv =====
// Top level: calibration register file and the compensation sequencer.
// Depends on htc_pkg, htc_seq (which holds htc_mul).
//
//   channel  handshake              payload
//   in       in_valid / in_ready    func, raw_sample
//   out      out_valid / out_ready  kind, compensated
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each product runs on one bit-serial multiplier; a temperature transaction takes
// three products, a humidity transaction eight products.
// One transaction at a time; a finished result waits in the output register.
// Reset clears calibration registers, fine temperature and all control state.
// cfg_ready is always high.
module humidity_temperature_compensation_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               func,
	input  logic [19:0]        raw_sample,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic signed [17:0] compensated,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	htc_pkg::cal_t cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				htc_pkg::REG_T1:   cal_q.t1  <= cfg_data[15:0];
				htc_pkg::REG_T2:   cal_q.t2  <= $signed(cfg_data[15:0]);
				htc_pkg::REG_T3:   cal_q.t3  <= $signed(cfg_data[15:0]);
				htc_pkg::REG_H1:   cal_q.h1  <= cfg_data[7:0];
				htc_pkg::REG_H2:   cal_q.h2  <= $signed(cfg_data[15:0]);
				htc_pkg::REG_H3:   cal_q.h3  <= cfg_data[7:0];
				htc_pkg::REG_H4H5: cal_q.h45 <= cfg_data;
				htc_pkg::REG_H6:   cal_q.h6  <= $signed(cfg_data[7:0]);
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	htc_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cal         (cal_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.raw_sample  (raw_sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.compensated (compensated)
	);

endmodule

// ===== test/htc_checker.sv =====
// Checker for the humidity/temperature compensation block: watches the cfg, in and out
// channels, predicts each result from its own copy of calibration and fine temperature.
// Depends on htc_pkg.
module htc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               func,
	input  logic [19:0]        raw_sample,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               kind,
	input  logic signed [17:0] compensated,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [3:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	output int unsigned        errors,
	output int unsigned        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        kind;
		logic [17:0] value;
	} reading_t;

	reading_t      expected_q[$];
	htc_pkg::cal_t cal;
	logic [31:0]   fine_t;

	function automatic logic [31:0] sar(input logic [31:0] x, input int n);
		return $unsigned($signed(x) >>> n);
	endfunction

	function automatic logic [31:0] sx(input logic [31:0] x, input int bits);
		logic [31:0] m;
		m = 32'd1 << (bits - 1);
		x = x & ((m << 1) - 32'd1);
		return (x ^ m) - m;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
			$signed(want), $time);
	endtask

	function automatic logic [17:0] predict_temperature(input logic [19:0] raw);
		logic [31:0] r, a, d, v1, v2, t;
		r  = {12'd0, raw};
		a  = (r >> 3) - ({16'd0, cal.t1} << 1);
		d  = (r >> 4) - {16'd0, cal.t1};
		v1 = sar(a * sx({16'd0, cal.t2}, 16), 11);
		v2 = sar(sar(d * d, 12) * sx({16'd0, cal.t3}, 16), 14);
		fine_t = v1 + v2;
		t = sar(fine_t * 32'd5 + htc_pkg::TEMP_ROUND, 8);
		if ($signed(t) < htc_pkg::TEMP_MIN) t = htc_pkg::TEMP_MIN;
		else if ($signed(t) > htc_pkg::TEMP_MAX) t = htc_pkg::TEMP_MAX;
		return t[17:0];
	endfunction

	function automatic logic [17:0] predict_humidity(input logic [19:0] raw);
		logic [31:0] h, h4, h5, v, p, q, s;
		h  = {16'd0, raw[15:0]};
		h4 = sx({8'd0, cal.h45}, 12);
		h5 = sx({8'd0, cal.h45} >> 12, 12);
		v  = fine_t - htc_pkg::HUM_FINE_OFFSET;
		p  = sar((h << 14) - (h4 << 20) - h5 * v + htc_pkg::HUM_ROUND_A, 15);
		q  = sar(v * sx({24'd0, cal.h6}, 8), 10)
			* (sar(v * {24'd0, cal.h3}, 11) + htc_pkg::HUM_BIAS_B);
		q  = sar(q, 10) + htc_pkg::HUM_BIAS_C;
		q  = sar(q * sx({16'd0, cal.h2}, 16) + htc_pkg::HUM_ROUND_D, 14);
		v  = p * q;
		s  = sar(v, 15);
		v  = v - sar(sar(s * s, 7) * {24'd0, cal.h1}, 4);
		if ($signed(v) < 0) v = 32'd0;
		if ($signed(v) > $signed(htc_pkg::HUM_LIMIT)) v = htc_pkg::HUM_LIMIT;
		return v[29:12];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			cal         <= '0;
			fine_t      <= '0;
			errors      <= 0;
			outstanding <= 0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					htc_pkg::REG_T1:   cal.t1  = cfg_data[15:0];
					htc_pkg::REG_T2:   cal.t2  = cfg_data[15:0];
					htc_pkg::REG_T3:   cal.t3  = cfg_data[15:0];
					htc_pkg::REG_H1:   cal.h1  = cfg_data[7:0];
					htc_pkg::REG_H2:   cal.h2  = cfg_data[15:0];
					htc_pkg::REG_H3:   cal.h3  = cfg_data[7:0];
					htc_pkg::REG_H4H5: cal.h45 = cfg_data;
					htc_pkg::REG_H6:   cal.h6  = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				want.kind  = func;
				want.value = (func == htc_pkg::FUNC_HUM) ? predict_humidity(raw_sample)
					: predict_temperature(raw_sample);
				expected_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected transaction", {31'd0, kind}, 32'd0);
				end else begin
					want = expected_q.pop_front();
					if (kind !== want.kind)
						report("kind", {31'd0, kind}, {31'd0, want.kind});
					if (compensated !== want.value)
						report("compensated", {{14{compensated[17]}}, compensated},
							{{14{want.value[17]}}, want.value});
				end
			end
			outstanding <= expected_q.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Top of the compensation testbench: clock, reset, calibration phases, stimulus and verdict.
// Depends on htc_pkg, humidity_temperature_compensation_top and htc_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               func = htc_pkg::FUNC_TEMP;
	logic [19:0]        raw_sample = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               kind;
	logic signed [17:0] compensated;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [3:0]         cfg_index = '0;
	logic [23:0]        cfg_data = '0;
	int unsigned        errors, outstanding;

	int unsigned n_temp, n_hum, n_cfg;
	bit          no_idle;
	bit          hold_req;

	always #1 clk = ~clk;

	humidity_temperature_compensation_top u_dut (.*);

	htc_checker u_chk (.*);

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 9);
			if (hold_req) begin
				n = 3000;
				hold_req = 0;
			end
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	task automatic send(input logic f, input logic [19:0] raw);
		int n;
		n = no_idle ? 0 : $urandom_range(0, 9);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		raw_sample <= raw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (f == htc_pkg::FUNC_HUM) n_hum++;
		else n_temp++;
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cal(input logic [3:0] idx, input logic [23:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		n_cfg++;
	endtask

	// sel 0 typical part, 1 all high, 2 all low, 3 random, 4 all zero
	task automatic load_cal(input int sel);
		logic [23:0] v[8];
		case (sel)
			0: v = '{24'd27504, 24'd26435, 24'hFFFC18, 24'd75, 24'd362, 24'd0,
				24'h032139, 24'd30};
			1: v = '{24'hFFFF, 24'h7FFF, 24'h7FFF, 24'hFF, 24'h7FFF, 24'hFF,
				24'h7FF7FF, 24'h7F};
			2: v = '{24'h0, 24'h8000, 24'h8000, 24'h0, 24'h8000, 24'h0,
				24'h800800, 24'h80};
			3: foreach (v[i]) v[i] = 24'($urandom);
			default: v = '{default: 24'd0};
		endcase
		foreach (v[i]) write_cal(i[3:0], v[i]);
		write_cal(4'(8 + $urandom_range(0, 7)), 24'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int sel;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration: humidity before any temperature, extremes
		send(htc_pkg::FUNC_HUM, 20'h0);
		send(htc_pkg::FUNC_HUM, 20'hFFFFF);
		send(htc_pkg::FUNC_TEMP, 20'h0);
		send(htc_pkg::FUNC_TEMP, 20'hFFFFF);
		send(htc_pkg::FUNC_HUM, 20'h8000);
		drain();
		load_cal(0);
		send(htc_pkg::FUNC_TEMP, 20'd519888);
		send(htc_pkg::FUNC_HUM, 20'd30000);
		send(htc_pkg::FUNC_HUM, 20'hF7530);
		send(htc_pkg::FUNC_TEMP, 20'h0);
		send(htc_pkg::FUNC_HUM, 20'h0);
		send(htc_pkg::FUNC_TEMP, 20'hFFFFF);
		send(htc_pkg::FUNC_HUM, 20'hFFFF);
		send(htc_pkg::FUNC_TEMP, 20'h80000);
		send(htc_pkg::FUNC_HUM, 20'h0FFFF);
		drain();
		load_cal(1);
		send(htc_pkg::FUNC_TEMP, 20'hFFFFF);
		send(htc_pkg::FUNC_HUM, 20'hFFFF);
		send(htc_pkg::FUNC_TEMP, 20'h0);
		send(htc_pkg::FUNC_HUM, 20'h0);
		drain();
		load_cal(2);
		send(htc_pkg::FUNC_TEMP, 20'hFFFFF);
		send(htc_pkg::FUNC_HUM, 20'hFFFF);
		send(htc_pkg::FUNC_TEMP, 20'h0);
		send(htc_pkg::FUNC_HUM, 20'h0);

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			sel = (ph < 3) ? 0 : (ph == 3) ? 1 : (ph == 4) ? 2 : (ph == 7) ? 4 : 3;
			load_cal(sel);
			no_idle = (ph == 2 || ph == 6);
			for (int i = 0; i < 216; i++) begin
				if (ph == 1 && i == 10) hold_req = 1;
				if ($urandom_range(0, 4) != 0) begin
					send(htc_pkg::FUNC_TEMP, 20'($urandom_range(380000, 660000)));
					send(htc_pkg::FUNC_HUM, 20'($urandom_range(15000, 45000)));
					i++;
				end else begin
					send(1'($urandom_range(0, 1)), 20'($urandom));
				end
			end
		end
		no_idle = 0;
		drain();
		repeat (300) @(posedge clk);

		$display("covered %0d temperature and %0d humidity transactions, %0d calibration writes",
			n_temp, n_hum, n_cfg);
		if (errors == 0 && outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/htc_pkg.sv
rtl/htc_mul.sv
rtl/htc_seq.sv
rtl/humidity_temperature_compensation_top.sv
test/htc_checker.sv
test/tb_top.sv
